FILE: rtl/core/dbps_pkg.sv
package dbps_pkg;

    // Pattern capacity and byte counter width
    localparam int PATTERN_MAX    = 32;
    localparam int OFFSET_BITS    = 32;
    localparam int LEN_W          = $clog2(PATTERN_MAX + 1);
    localparam int MATCH_OFFSET_W = 32;

    // Command codes
    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_HAY     = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_byte;
        logic       care;
        logic       last;
    } in_beat_t;

    typedef struct packed {
        logic                      match_found;
        logic [MATCH_OFFSET_W-1:0] match_offset;
        logic                      not_found;
        logic                      pattern_overflow;
    } out_beat_t;

    // Per-cycle control broadcast to every cell
    typedef struct packed {
        logic pat_shift;
        logic win_shift;
        logic fill_clear;
    } cell_ctrl_t;

    // What one cell hands to its right-hand neighbour
    typedef struct packed {
        logic [7:0] win;
        logic [7:0] pat;
        logic       care;
        logic       act;
        logic       fill;
    } cell_link_t;

endpackage

FILE: rtl/core/masked_byte_pattern_search_unit.sv
// Each result beat is registered in the output buffer, via its skid entry while a
// stall holds the main register. Throughput: one input beat per cycle unless stalled,
// set by the combinational compare across the cell row; every input beat gives one
// result beat. A two-entry output buffer lets input run on while one result waits.
// Reset (rst_n low, asynchronous) empties the pattern, closes it, clears the
// search and drops any result beats held in the output buffer.
module masked_byte_pattern_search_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  dbps_pkg::in_beat_t  item,
    output logic               result_valid,
    input  logic               result_stall,
    output dbps_pkg::out_beat_t result
);
    import dbps_pkg::*;

    // Search and pattern bookkeeping
    logic                   closed_reg, closed_next;
    logic                   found_reg, found_next;
    logic [OFFSET_BITS-1:0] seen_reg, seen_next;
    logic [LEN_W-1:0]       len_reg, len_next;

    logic       take;
    logic       is_load;
    logic       is_hay;
    logic       is_restart;
    logic       search_restart;
    logic       row_full;
    logic       representable;
    logic       match;
    logic       buf_full;
    cell_ctrl_t ctrl;
    out_beat_t  beat;

    logic [OFFSET_BITS-1:0] seen_inc;
    logic [OFFSET_BITS-1:0] start_offset;

    cell_link_t             link_in  [PATTERN_MAX];
    cell_link_t             link_out [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] ok_vec;

    assign take       = item_valid && !item_stall;
    assign is_load    = take && (item.command == CMD_LOAD);
    assign is_hay     = take && (item.command == CMD_HAY);
    assign is_restart = take && (item.command == CMD_RESTART);

    // A pattern byte, an explicit restart or the final haystack byte restarts the search
    assign search_restart = is_load || is_restart || (is_hay && item.last);

    // The far cell holds an active byte only when the pattern is at capacity
    assign row_full = link_out[PATTERN_MAX-1].act;

    // Pattern bytes shift in at cell 0, so cell p ends up holding the byte that
    // must line up with the window byte p places back from the newest.
    // A closed pattern is replaced: hold only the incoming byte active.
    assign ctrl.pat_shift  = is_load && (closed_reg || !row_full);
    assign ctrl.win_shift  = is_hay;
    assign ctrl.fill_clear = search_restart;

    assign link_in[0].win  = item.data_byte;
    assign link_in[0].pat  = item.data_byte;
    assign link_in[0].care = item.care;
    assign link_in[0].act  = 1'b1;
    assign link_in[0].fill = 1'b1;

    for (genvar p = 1; p < PATTERN_MAX; p++)
    begin : g_link
        always_comb
        begin
            link_in[p]     = link_out[p-1];
            link_in[p].act = link_out[p-1].act && !closed_reg;
        end
    end

    for (genvar p = 0; p < PATTERN_MAX; p++)
    begin : g_cell
        dbps_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .link_in  (link_in[p]),
            .link_out (link_out[p]),
            .ok       (ok_vec[p])
        );
    end

    // The count stops at all ones; from there no match can complete
    assign representable = (seen_reg != {OFFSET_BITS{1'b1}});
    assign seen_inc      = seen_reg + {{(OFFSET_BITS-1){1'b0}}, 1'b1};
    assign start_offset  = seen_inc - OFFSET_BITS'(len_reg);

    // Each cell's fill bit guards against comparing bytes never delivered
    assign match = is_hay && !found_reg && closed_reg && representable && (&ok_vec);

    always_comb
    begin
        beat                  = '0;
        beat.match_found      = match;
        beat.not_found        = is_hay && item.last && !found_reg && !match;
        beat.pattern_overflow = is_load && !closed_reg && row_full;
        if (match && (len_reg != '0))
        begin
            beat.match_offset = MATCH_OFFSET_W'(start_offset);
        end
    end

    always_comb
    begin
        closed_next = closed_reg;
        len_next    = len_reg;
        found_next  = found_reg;
        seen_next   = seen_reg;

        if (is_load)
        begin
            closed_next = item.last;
            if (closed_reg)
            begin
                len_next = {{(LEN_W-1){1'b0}}, 1'b1};
            end
            else if (!row_full)
            begin
                len_next = len_reg + {{(LEN_W-1){1'b0}}, 1'b1};
            end
        end

        if (search_restart)
        begin
            found_next = 1'b0;
            seen_next  = '0;
        end
        else if (is_hay)
        begin
            if (match)
            begin
                found_next = 1'b1;
            end
            if (representable)
            begin
                seen_next = seen_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            closed_reg <= 1'b1;
            len_reg    <= '0;
            found_reg  <= 1'b0;
            seen_reg   <= '0;
        end
        else
        begin
            closed_reg <= closed_next;
            len_reg    <= len_next;
            found_reg  <= found_next;
            seen_reg   <= seen_next;
        end
    end

    // Result register plus skid entry; stall input only when both are occupied
    dbps_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take),
        .push_data (beat),
        .full      (buf_full),
        .out_valid (result_valid),
        .out_stall (result_stall),
        .out_data  (result)
    );

    assign item_stall = buf_full;

endmodule

FILE: rtl/core/dbps_cell.sv
module dbps_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  dbps_pkg::cell_ctrl_t ctrl,
    input  dbps_pkg::cell_link_t link_in,
    output dbps_pkg::cell_link_t link_out,
    output logic                ok
);
    import dbps_pkg::*;

    logic [7:0] win_reg, win_next;
    logic [7:0] pat_reg, pat_next;
    logic       care_reg, care_next;
    logic       act_reg, act_next;
    logic       fill_reg, fill_next;

    always_comb
    begin
        win_next  = ctrl.win_shift ? link_in.win : win_reg;
        pat_next  = ctrl.pat_shift ? link_in.pat : pat_reg;
        care_next = ctrl.pat_shift ? link_in.care : care_reg;
        act_next  = ctrl.pat_shift ? link_in.act : act_reg;
        if (ctrl.fill_clear)
        begin
            fill_next = 1'b0;
        end
        else if (ctrl.win_shift)
        begin
            fill_next = link_in.fill;
        end
        else
        begin
            fill_next = fill_reg;
        end
    end

    // Compare against the byte entering this cell on this beat
    assign ok = !act_reg || (link_in.fill && (!care_reg || (pat_reg == link_in.win)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg  <= 1'b0;
            fill_reg <= 1'b0;
        end
        else
        begin
            act_reg  <= act_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg  <= win_next;
        pat_reg  <= pat_next;
        care_reg <= care_next;
    end

    assign link_out.win  = win_reg;
    assign link_out.pat  = pat_reg;
    assign link_out.care = care_reg;
    assign link_out.act  = act_reg;
    assign link_out.fill = fill_reg;

endmodule

FILE: rtl/core/dbps_obuf.sv
module dbps_obuf (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  dbps_pkg::out_beat_t push_data,
    output logic               full,
    output logic               out_valid,
    input  logic               out_stall,
    output dbps_pkg::out_beat_t out_data
);
    import dbps_pkg::*;

    logic      main_valid_reg, main_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    out_beat_t main_reg, main_next;
    out_beat_t skid_reg, skid_next;
    logic      pop;

    assign pop = main_valid_reg && !out_stall;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (pop || !main_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_next       = push_data;
                main_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_next       = push_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

endmodule

FILE: rtl/core/dbps_checker.sv
module dbps_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               item_valid,
    input logic               item_stall,
    input dbps_pkg::in_beat_t  item,
    input logic               result_valid,
    input logic               result_stall,
    input dbps_pkg::out_beat_t result
);
    import dbps_pkg::*;

    // A match and a miss never share a beat
    a_found_excl: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.match_found && result.not_found))
        else $error("match_found and not_found both set");

    // Offset is zero unless a match is reported
    a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.match_found) |-> (result.match_offset == '0))
        else $error("match_offset nonzero without a match");

    // Input can only stall while a result is held
    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid)
        else $error("input stalled with no result held");

    // With no result offered, the next cycle cannot stall input
    a_stall_after_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |=> !item_stall)
        else $error("input stalled one cycle after an empty output");

    // A stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(result)))
        else $error("stalled result beat changed");

endmodule

bind masked_byte_pattern_search_unit dbps_checker u_dbps_checker (.*);
